>>> src/bitmap_page_allocator_core_defines.svh
// Assertion helpers for the allocator RTL
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the core clock, off during reset
`define BPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpa check failed");

// Next-cycle implication, sampled on the core clock, off during reset
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpa check failed");

`endif

>>> src/bpa_pkg.sv
package bpa_pkg;

    localparam int TOTAL_PAGES = 1024;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int CFG_W     = 11;
    localparam int CNT_W     = 11;
    localparam int IDX_W     = 10;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [1:0] WRAP_LIMIT = 2'd2;

    // register index (byte address bit 2)
    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_END   = 1'b1;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_ALIGN = 2'd2,
        REQ_FREE  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_INIT,
        ST_MODR_GO,
        ST_MODR_W,
        ST_MODC_GO,
        ST_MODC_W,
        ST_RD,
        ST_PROBE,
        ST_RMW_RD,
        ST_RMW_WR
    } t_state;

    typedef struct packed {
        logic       idle;
        logic [1:0] wrap_cnt;
    } t_eng_stat;

endpackage

>>> src/bpa_map_ram.sv
module bpa_map_ram
    import bpa_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [WORD_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [WORD_BITS-1:0] o_rdata
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/bpa_mod_unit.sv
module bpa_mod_unit
    import bpa_pkg::*;
#(
    parameter int W = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_rem
);

    localparam int SW = $clog2(W + 1);

    logic [SW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  r_x;
    logic [W-1:0]  r_d;
    logic [W-1:0]  r_rem;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // one restoring step per cycle
    assign trial = {r_rem, r_x[W-1]};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift dividend in, keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[W-2:0], 1'b0};
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
            end else begin
                r_rem <= trial[W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> src/bpa_engine.sv
module bpa_engine
    import bpa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  t_req             i_req_type,
    input  logic [CNT_W-1:0] i_page_count,
    input  logic [IDX_W-1:0] i_page_index,
    input  logic [CNT_W-1:0] i_align_pages,
    input  logic [CFG_W-1:0] i_region_first,
    input  logic [CFG_W-1:0] i_region_end,
    output logic             o_done,
    output logic             o_ok,
    output logic [IDX_W-1:0] o_first_page,
    output t_eng_stat        o_stat
);

    localparam int PW        = $clog2(TOTAL_PAGES);
    localparam int CW        = (PW + 1 > 12) ? PW + 1 : 12;
    localparam int MAP_WORDS = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [CW-1:0] TOTAL_C = CW'(TOTAL_PAGES);
    localparam logic [AW-1:0] LAST_W  = AW'(MAP_WORDS - 1);

    t_state        r_state, n_state;
    t_req          r_op, n_op;
    logic [PW-1:0] r_cursor, n_cursor;
    logic [1:0]    r_wrap, n_wrap;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_align, n_align;
    logic [CW-1:0] r_run, n_run;
    logic [CW-1:0] r_first, n_first;
    logic [CW-1:0] r_amod, n_amod;
    logic [CW-1:0] r_rmod, n_rmod;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [AW-1:0] r_w, n_w;
    logic [AW-1:0] r_wlast, n_wlast;
    logic [AW-1:0] r_ldw, n_ldw;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic                 mod_start, mod_done;
    logic [CW-1:0]        mod_x, mod_rem;

    logic [CW-1:0]        restart, endc, cur_cw, nxt, new_cur, wc_base;
    logic [CW-1:0]        run_inc, amod_inc, first_eff, mark_hi, free_hi;
    logic [1:0]           wc_inc;
    logic                 avail, wrapped, fail, cond, hit;
    logic [WORD_BITS-1:0] mask;

    // restart page and clipped region end
    assign restart = (CW'(i_region_first) < TOTAL_C) ? CW'(i_region_first) : '0;
    assign endc    = (CW'(i_region_end) > TOTAL_C) ? TOTAL_C : CW'(i_region_end);

    // probe of the page under the cursor
    assign cur_cw    = CW'(r_cursor);
    assign avail     = ram_rdata[r_cursor[BIT_W-1:0]];
    assign nxt       = cur_cw + 1'b1;
    assign wrapped   = (nxt >= TOTAL_C);
    assign new_cur   = wrapped ? restart : nxt;
    assign wc_inc    = r_wrap + 1'b1;
    assign fail      = wrapped && (wc_inc > WRAP_LIMIT);
    assign cond      = avail && ((r_run != '0) || (r_op != REQ_ALIGN) || (r_amod == '0));
    assign run_inc   = r_run + 1'b1;
    assign hit       = cond && (run_inc == r_count);
    assign amod_inc  = r_amod + 1'b1;
    assign first_eff = (r_run == '0) ? cur_cw : r_first;
    assign mark_hi   = first_eff + r_count;
    assign free_hi   = (CW'(i_page_index) + CW'(i_page_count) > TOTAL_C) ? TOTAL_C
                     : CW'(i_page_index) + CW'(i_page_count);

    // bits of word r_w whose pages fall in [r_lo, r_hi)
    assign wc_base = CW'(r_w) << BIT_W;
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = ((wc_base + CW'(b)) >= r_lo) && ((wc_base + CW'(b)) < r_hi);
        end
    end

    assign mod_x = (r_state == ST_MODR_GO) ? restart : cur_cw;

    bpa_map_ram #(
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpa_mod_unit #(
        .W (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_x),
        .i_divisor  (r_align),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_cursor <= '0;
            r_wrap   <= '0;
            r_w      <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_wrap   <= n_wrap;
            r_w      <= n_w;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_count <= n_count;
        r_align <= n_align;
        r_run   <= n_run;
        r_first <= n_first;
        r_amod  <= n_amod;
        r_rmod  <= n_rmod;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_wlast <= n_wlast;
        r_ldw   <= n_ldw;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_cursor     = r_cursor;
        n_wrap       = r_wrap;
        n_count      = r_count;
        n_align      = r_align;
        n_run        = r_run;
        n_first      = r_first;
        n_amod       = r_amod;
        n_rmod       = r_rmod;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_w          = r_w;
        n_wlast      = r_wlast;
        n_ldw        = r_ldw;
        ram_we       = 1'b0;
        ram_waddr    = r_w;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_w;
        mod_start    = 1'b0;
        o_done       = 1'b0;
        o_ok         = 1'b1;
        o_first_page = '0;
        case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
                if (r_w == LAST_W) begin
                    n_w     = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_op    = i_req_type;
                    n_count = CW'(i_page_count);
                    n_align = (i_align_pages == '0) ? CW'(1) : CW'(i_align_pages);
                    n_run   = '0;
                    case (i_req_type)
                        REQ_INIT: begin
                            n_lo    = CW'(i_region_first);
                            n_hi    = endc;
                            n_w     = '0;
                            n_state = ST_INIT;
                        end
                        REQ_ALLOC, REQ_ALIGN: begin
                            if (i_page_count == '0) begin
                                o_done = 1'b1;
                                o_ok   = 1'b0;
                            end else if (i_req_type == REQ_ALIGN) begin
                                n_state = ST_MODR_GO;
                            end else begin
                                n_state = ST_RD;
                            end
                        end
                        default: begin
                            if (CW'(i_page_index) < cur_cw) begin
                                n_cursor = PW'(i_page_index);
                            end
                            n_lo = CW'(i_page_index);
                            n_hi = free_hi;
                            if (CW'(i_page_index) < free_hi) begin
                                n_w     = AW'(CW'(i_page_index) >> BIT_W);
                                n_wlast = AW'((free_hi - 1'b1) >> BIT_W);
                                n_state = ST_RMW_RD;
                            end else begin
                                o_done = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = mask;
                if (r_w == LAST_W) begin
                    n_w      = '0;
                    n_cursor = PW'(restart);
                    o_done   = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_w = r_w + 1'b1;
                end
            end
            ST_MODR_GO: begin
                mod_start = 1'b1;
                n_state   = ST_MODR_W;
            end
            ST_MODR_W: begin
                if (mod_done) begin
                    n_rmod  = mod_rem;
                    n_state = ST_MODC_GO;
                end
            end
            ST_MODC_GO: begin
                mod_start = 1'b1;
                n_state   = ST_MODC_W;
            end
            ST_MODC_W: begin
                if (mod_done) begin
                    n_amod  = mod_rem;
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cur_cw >> BIT_W);
                n_ldw     = AW'(cur_cw >> BIT_W);
                n_state   = ST_PROBE;
            end
            ST_PROBE: begin
                n_cursor = PW'(new_cur);
                n_amod   = wrapped ? r_rmod : ((amod_inc == r_align) ? '0 : amod_inc);
                if (wrapped) begin
                    n_wrap = fail ? 2'd0 : wc_inc;
                end
                if (fail) begin
                    o_done  = 1'b1;
                    o_ok    = 1'b0;
                    n_state = ST_IDLE;
                end else if (hit) begin
                    n_first = first_eff;
                    n_lo    = first_eff;
                    n_hi    = mark_hi;
                    n_w     = AW'(first_eff >> BIT_W);
                    n_wlast = AW'((mark_hi - 1'b1) >> BIT_W);
                    n_state = ST_RMW_RD;
                end else begin
                    if (cond) begin
                        n_first = first_eff;
                        n_run   = run_inc;
                    end else begin
                        n_run = '0;
                    end
                    if (wrapped) begin
                        n_run = '0;
                    end
                    if (AW'(new_cur >> BIT_W) != r_ldw) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RMW_RD: begin
                ram_re  = 1'b1;
                n_state = ST_RMW_WR;
            end
            ST_RMW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = (r_op == REQ_FREE) ? (ram_rdata | mask) : (ram_rdata & ~mask);
                if (r_w == r_wlast) begin
                    n_w          = '0;
                    o_done       = 1'b1;
                    o_first_page = (r_op == REQ_FREE) ? '0 : IDX_W'(r_first);
                    n_state      = ST_IDLE;
                end else begin
                    n_w     = r_w + 1'b1;
                    n_state = ST_RMW_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stat.idle     = (r_state == ST_IDLE);
    assign o_stat.wrap_cnt = r_wrap;

endmodule

>>> src/bitmap_page_allocator_core.sv
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------------------------
// request   | i_req_valid / o_req_ready  | i_req_type i_page_count i_page_index
//           |                            | i_align_pages
// response  | o_rsp_valid / i_rsp_ready  | o_ok o_first_page
// config    | psel penable pwrite pready | paddr pwdata prdata
//
// Init writes each map word in turn; free reads and rewrites each map word touched.
// Allocate reads one map word, then probes its pages one at a time; an aligned allocate
// first computes two remainders by restoring division, and marking reads and rewrites
// each map word of the run. One request is in flight at a time.
// After reset a clearing pass writes zero to all TOTAL_PAGES/32 map words; requests wait.
// A stalled response holds; a new request is taken once the response register frees.
`include "bitmap_page_allocator_core_defines.svh"

module bitmap_page_allocator_core
    import bpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [1:0]        i_req_type,
    input  logic [CNT_W-1:0]  i_page_count,
    input  logic [IDX_W-1:0]  i_page_index,
    input  logic [CNT_W-1:0]  i_align_pages,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output logic              o_ok,
    output logic [IDX_W-1:0]  o_first_page
);

    logic [CFG_W-1:0] r_region_first;
    logic [CFG_W-1:0] r_region_end;
    logic             r_rsp_valid;
    logic             r_ok;
    logic [IDX_W-1:0] r_first_page;
    logic             eng_done, eng_ok;
    logic [IDX_W-1:0] eng_first;
    t_eng_stat        eng_stat;
    logic             req_take;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_first <= '0;
            r_region_end   <= CFG_W'(1024);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FIRST: r_region_first <= pwdata[CFG_W-1:0];
                REG_END:   r_region_end   <= pwdata[CFG_W-1:0];
                default:   r_region_end   <= r_region_end;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_END) ? DATA_W'(r_region_end) : DATA_W'(r_region_first);

    // take a request when the engine is idle and the response slot frees
    assign o_req_ready = eng_stat.idle && (!r_rsp_valid || i_rsp_ready);
    assign req_take    = i_req_valid && o_req_ready;

    bpa_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (req_take),
        .i_req_type     (t_req'(i_req_type)),
        .i_page_count   (i_page_count),
        .i_page_index   (i_page_index),
        .i_align_pages  (i_align_pages),
        .i_region_first (r_region_first),
        .i_region_end   (r_region_end),
        .o_done         (eng_done),
        .o_ok           (eng_ok),
        .o_first_page   (eng_first),
        .o_stat         (eng_stat)
    );

    // hold the response until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (eng_done) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_done) begin
            r_ok         <= eng_ok;
            r_first_page <= eng_first;
        end
    end

    assign o_rsp_valid  = r_rsp_valid;
    assign o_ok         = r_ok;
    assign o_first_page = r_first_page;

    `BPA_ASSERT_NOW(a_wrap_range, 1'b1, eng_stat.wrap_cnt != 2'd3)
    `BPA_ASSERT_NEXT(a_one_in_flight, req_take, o_rsp_valid || !eng_stat.idle)
    `BPA_ASSERT_NOW(a_fail_zero, o_rsp_valid && !o_ok, o_first_page == '0)
    `BPA_ASSERT_NOW(a_done_idle_slot, eng_done, !r_rsp_valid || i_rsp_ready || req_take)

endmodule

>>> tb/tb_bitmap_page_allocator_core.sv
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_core;
    import bpa_pkg::*;

    localparam int NUM_PAGES = 1024;
    localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
    localparam logic [ADDR_W-1:0] ADDR_FIRST = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_END   = 3'd4;

    typedef struct {
        bit              ok;
        logic [IDX_W-1:0] first_page;
    } t_alloc_rsp;

    typedef struct {
        int start;
        int count;
    } t_run;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_req_valid;
    logic              o_req_ready;
    logic [1:0]        i_req_type;
    logic [CNT_W-1:0]  i_page_count;
    logic [IDX_W-1:0]  i_page_index;
    logic [CNT_W-1:0]  i_align_pages;
    logic              o_rsp_valid;
    logic              i_rsp_ready;
    logic              o_ok;
    logic [IDX_W-1:0]  o_first_page;

    // shadow allocator state
    bit [WORD_BITS-1:0] shadow_map [NUM_WORDS];
    int shadow_cursor;
    int shadow_wraps;
    int shadow_first;
    int shadow_end;

    t_alloc_rsp rsp_pending [$];
    t_run       live_runs [$];
    int         err_count;
    int         snd_idle;
    int         rcv_idle;

    bitmap_page_allocator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req_type   (i_req_type),
        .i_page_count (i_page_count),
        .i_page_index (i_page_index),
        .i_align_pages(i_align_pages),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_ok         (o_ok),
        .o_first_page (o_first_page)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit page_free(int pg);
        if (pg >= NUM_PAGES) return 1'b0;
        return shadow_map[pg / WORD_BITS][pg % WORD_BITS];
    endfunction

    function automatic void page_set(int pg, bit freed);
        if (pg < NUM_PAGES) shadow_map[pg / WORD_BITS][pg % WORD_BITS] = freed;
    endfunction

    function automatic int restart_pg();
        return (shadow_first < NUM_PAGES) ? shadow_first : 0;
    endfunction

    // compute the response of one request and advance the shadow state
    function automatic t_alloc_rsp alloc_predict(t_req rq, int cnt, int idx, int aln);
        t_alloc_rsp r;
        int  run;
        int  first;
        int  pg;
        int  lim;
        bit  wrapped;
        bit  avail;
        r.ok = 1'b1;
        r.first_page = '0;
        run = 0;
        first = 0;
        case (rq)
            REQ_INIT: begin
                lim = (shadow_end > NUM_PAGES) ? NUM_PAGES : shadow_end;
                foreach (shadow_map[w]) shadow_map[w] = '0;
                for (pg = shadow_first; pg < lim; pg++) page_set(pg, 1'b1);
                shadow_cursor = restart_pg();
            end
            REQ_ALLOC, REQ_ALIGN: begin
                if (aln == 0) aln = 1;
                if (cnt == 0) begin
                    r.ok = 1'b0;
                    return r;
                end
                forever begin
                    pg = shadow_cursor;
                    avail = page_free(pg);
                    shadow_cursor = pg + 1;
                    wrapped = 1'b0;
                    if (shadow_cursor >= NUM_PAGES) begin
                        shadow_cursor = restart_pg();
                        wrapped = 1'b1;
                        shadow_wraps++;
                        if (shadow_wraps > WRAP_LIMIT) begin
                            shadow_wraps = 0;
                            r.ok = 1'b0;
                            return r;
                        end
                    end
                    if (avail && (run > 0 || rq != REQ_ALIGN || (pg % aln) == 0)) begin
                        if (run == 0) first = pg;
                        run++;
                        if (run == cnt) begin
                            for (int k = 0; k < cnt; k++) page_set(first + k, 1'b0);
                            r.first_page = first[IDX_W-1:0];
                            return r;
                        end
                    end else begin
                        run = 0;
                    end
                    if (wrapped) run = 0;
                end
            end
            default: begin
                for (int k = 0; k < cnt; k++) page_set(idx + k, 1'b1);
                if (idx < shadow_cursor) shadow_cursor = idx;
            end
        endcase
        return r;
    endfunction

    // send one request; valid stays high across back-to-back requests
    task automatic send_req(t_req rq, int cnt, int idx, int aln);
        t_alloc_rsp r;
        if ($urandom_range(99) < snd_idle) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_req_valid   <= 1'b1;
        i_req_type    <= rq;
        i_page_count  <= cnt[CNT_W-1:0];
        i_page_index  <= idx[IDX_W-1:0];
        i_align_pages <= aln[CNT_W-1:0];
        do @(posedge i_clk); while (!o_req_ready);
        r = alloc_predict(rq, cnt, idx, aln);
        rsp_pending.push_back(r);
        if (rq == REQ_INIT) live_runs.delete();
        if ((rq == REQ_ALLOC || rq == REQ_ALIGN) && r.ok)
            live_runs.push_back('{int'(r.first_page), cnt});
    endtask

    // drop valid and wait until every response is back
    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [ADDR_W-1:0] addr, int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FIRST) shadow_first = value & 'h7ff;
        else shadow_end = value & 'h7ff;
    endtask

    task automatic set_region(int first, int last);
        drain();
        reg_write(ADDR_FIRST, first);
        reg_write(ADDR_END, last);
    endtask

    // one random request, mostly well-formed alloc/free traffic
    task automatic random_req();
        int sel;
        int pick;
        int aln;
        t_run run;
        sel = $urandom_range(99);
        if (sel < 2) begin
            send_req(REQ_INIT, $urandom_range(2047), $urandom_range(1023), $urandom_range(2047));
        end else if (sel < 5) begin
            // noise over the full field widths
            send_req(t_req'($urandom_range(3)), $urandom_range(2047), $urandom_range(1023),
                     $urandom_range(2047));
        end else if (sel < 40 && live_runs.size() != 0) begin
            pick = $urandom_range(live_runs.size() - 1);
            run = live_runs[pick];
            live_runs.delete(pick);
            send_req(REQ_FREE, run.count, run.start, $urandom_range(2047));
        end else if (sel < 44) begin
            send_req(REQ_FREE, $urandom_range(1, 16), $urandom_range(1023), 0);
        end else if (sel < 70) begin
            aln = ($urandom_range(3) == 0) ? $urandom_range(1, 48) : (1 << $urandom_range(6));
            send_req(REQ_ALIGN, $urandom_range(1, 12), $urandom_range(1023), aln);
        end else begin
            send_req(REQ_ALLOC, ($urandom_range(9) == 0) ? $urandom_range(1, 96)
                                                        : $urandom_range(1, 8),
                     $urandom_range(1023), $urandom_range(2047));
        end
    endtask

    // check each accepted response against the oldest expectation
    always @(posedge i_clk) begin
        t_alloc_rsp e;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (rsp_pending.size() == 0) begin
                $display("%0t: unexpected response ok=%0b first_page=%0d",
                         $time, o_ok, o_first_page);
                err_count++;
            end else begin
                e = rsp_pending.pop_front();
                if (o_ok !== e.ok) begin
                    $display("%0t: ok mismatch expected %0b actual %0b", $time, e.ok, o_ok);
                    err_count++;
                end
                if (o_first_page !== e.first_page) begin
                    $display("%0t: first_page mismatch expected %0d actual %0d",
                             $time, e.first_page, o_first_page);
                    err_count++;
                end
            end
        end
        i_rsp_ready <= ($urandom_range(99) >= rcv_idle);
    end

    task automatic test_directed();
        send_req(REQ_INIT, 0, 0, 0);
        send_req(REQ_ALLOC, 1, 0, 0);
        send_req(REQ_ALLOC, 0, 0, 0);
        send_req(REQ_ALIGN, 3, 0, 0);
        send_req(REQ_ALIGN, 2, 0, 3);
        send_req(REQ_ALIGN, 1, 0, 1024);
        send_req(REQ_ALIGN, 1, 0, 2047);
        send_req(REQ_ALLOC, 1024, 0, 0);
        send_req(REQ_FREE, 0, 0, 0);
        send_req(REQ_FREE, 2047, 1023, 2047);
        send_req(REQ_FREE, 1024, 0, 0);
        send_req(REQ_ALLOC, 1024, 1023, 0);
        send_req(REQ_ALLOC, 1, 0, 0);
        send_req(REQ_FREE, 1, 1023, 0);
        send_req(REQ_ALLOC, 2047, 0, 2047);
        send_req(REQ_INIT, 2047, 1023, 2047);
        send_req(REQ_ALLOC, 33, 682, 1365);
        send_req(REQ_ALIGN, 64, 341, 512);
    endtask

    // region extremes: empty, reversed, one page, beyond the store
    task automatic test_region_extremes();
        set_region(0, 0);
        send_req(REQ_INIT, 0, 0, 0);
        send_req(REQ_ALLOC, 1, 0, 0);
        set_region(600, 200);
        send_req(REQ_INIT, 0, 0, 0);
        send_req(REQ_FREE, 4, 700, 0);
        send_req(REQ_ALLOC, 4, 0, 0);
        set_region(1023, 1024);
        send_req(REQ_INIT, 0, 0, 0);
        send_req(REQ_ALLOC, 1, 0, 0);
        send_req(REQ_ALLOC, 1, 0, 0);
        set_region(2047, 2047);
        send_req(REQ_INIT, 0, 0, 0);
        send_req(REQ_FREE, 8, 10, 0);
        send_req(REQ_ALLOC, 2, 0, 0);
        set_region(1024, 2047);
        send_req(REQ_INIT, 0, 0, 0);
        send_req(REQ_FREE, 3, 1021, 0);
        send_req(REQ_ALLOC, 3, 0, 0);
    endtask

    task automatic test_random(int first, int last, int n);
        set_region(first, last);
        send_req(REQ_INIT, 0, 0, 0);
        repeat (n) random_req();
    endtask

    // hold the sender until all responses are back, then resume
    task automatic test_drain_pause();
        repeat (20) random_req();
        drain();
        repeat (20) random_req();
    endtask

    initial begin
        int lo;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_req_valid   = 1'b0;
        i_req_type    = REQ_INIT;
        i_page_count  = '0;
        i_page_index  = '0;
        i_align_pages = '0;
        i_rsp_ready   = 1'b0;
        err_count     = 0;
        snd_idle      = 0;
        rcv_idle      = 0;
        foreach (shadow_map[w]) shadow_map[w] = '0;
        shadow_cursor = 0;
        shadow_wraps  = 0;
        shadow_first  = 0;
        shadow_end    = 1024;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle = 28;
        rcv_idle = 66;
        test_directed();
        test_region_extremes();
        test_random(0, 1024, 420);
        snd_idle = 66;
        rcv_idle = 28;
        test_random(64, 960, 420);
        test_drain_pause();
        snd_idle = 0;
        rcv_idle = 0;
        lo = $urandom_range(512);
        test_random(lo, lo + $urandom_range(256, 512), 400);
        drain();

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
